// ===== rtl/ppu_pkg.sv =====
// ppu_pkg: shared types, constants and helpers of the particle pool update unit.
// No dependencies; imported by ppu_draw, ppu_search and the top level (ppu_ram does not use it).
package ppu_pkg;

  localparam int PPU_POOL_SIZE = 64;
  localparam int PPU_FRAC_BITS = 12;

  // fixed field widths of the item channels
  localparam int SLOT_W     = 6;
  localparam int DT_W       = 13;
  localparam int ACC_W      = 24;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 128;

  // free slot search looks at this many slots per cycle
  localparam int SRCH_LANES = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_CNT,
    ST_SEARCH,
    ST_DRAW,
    ST_SPAWN,
    ST_RD,
    ST_MUL,
    ST_WB
  } ppu_state_t;

  // order of the random draws for one respawned particle
  typedef enum logic [2:0] {
    DRAW_VEL_X,
    DRAW_VEL_Y,
    DRAW_VEL_Z,
    DRAW_RED,
    DRAW_GREEN,
    DRAW_BLUE
  } draw_kind_t;

  typedef struct packed {
    logic  en;
    logic  set;
    slot_t idx;
  } alive_upd_t;

  typedef struct packed {
    logic  done;
    slot_t slot;
  } srch_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ppu_ram.sv =====
// ppu_ram: generic single-port RAM, one access per cycle, registered read data.
// Depends on nothing.
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ppu_draw.sv =====
// ppu_draw: xorshift32 generator and scaling of one draw into a spawn range.
// Depends on ppu_pkg.
module ppu_draw import ppu_pkg::*; #(
  parameter int FRAC_BITS = PPU_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   seed_load,
  input  logic [31:0]            seed,
  input  logic                   step,
  input  draw_kind_t             kind,
  output logic signed [15:0]     value
);

  localparam int ONE   = 1 << FRAC_BITS;
  localparam int FIFTH = ONE / 5;

  logic [31:0]        rng_r;
  logic [31:0]        x1, x2, x3;
  logic [15:0]        span;
  logic signed [16:0] low;
  logic [31:0]        prod;
  logic signed [16:0] sum;

  always_comb begin
    x1 = rng_r ^ (rng_r << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
  end

  always_comb begin
    case (kind)
      DRAW_VEL_X, DRAW_VEL_Z: begin
        span = 16'(2 * FIFTH);
        low  = 17'(-FIFTH);
      end
      DRAW_VEL_Y: begin
        span = 16'(2 * ONE - FIFTH);
        low  = 17'(FIFTH);
      end
      DRAW_RED, DRAW_GREEN, DRAW_BLUE: begin
        span = 16'(ONE);
        low  = 17'sd0;
      end
      default: begin
        span = 16'(ONE);
        low  = 17'sd0;
      end
    endcase
  end

  // upper half of the new word scaled by the span
  assign prod  = x3[31:16] * span;
  assign sum   = low + $signed({1'b0, prod[31:16]});
  assign value = sum[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= 32'd1;
    end else if (seed_load) begin
      rng_r <= (seed == 32'd0) ? 32'd1 : seed;
    end else if (step) begin
      rng_r <= x3;
    end
  end

endmodule

// ===== rtl/ppu_search.sv =====
// ppu_search: live-slot flags and circular free slot search from the hint.
// Depends on ppu_pkg.
module ppu_search import ppu_pkg::*; #(
  parameter int POOL_SIZE = PPU_POOL_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  alive_upd_t upd,
  output srch_stat_t stat
);

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int SW    = ((IDX_W > 3) ? IDX_W : 3) + 1;

  logic [POOL_SIZE-1:0] alive_r;
  logic [IDX_W-1:0]     hint_r;
  logic [IDX_W-1:0]     pos_r;
  logic [CNT_W-1:0]     left_r;
  logic                 active_r;

  logic [SW-1:0]        lane_sum;
  logic [IDX_W-1:0]     lane_idx;
  logic                 found;
  logic [IDX_W-1:0]     hit_idx;
  logic [SW-1:0]        pos_adv;
  logic                 done;

  // lowest lane wins: scanned from the top down
  always_comb begin
    found    = 1'b0;
    hit_idx  = '0;
    lane_sum = '0;
    lane_idx = '0;
    for (int k = SRCH_LANES - 1; k >= 0; k--) begin
      lane_sum = SW'(pos_r) + SW'(k);
      if (lane_sum >= SW'(POOL_SIZE)) begin
        lane_sum = lane_sum - SW'(POOL_SIZE);
      end
      lane_idx = lane_sum[IDX_W-1:0];
      if (int'(left_r) > k) begin
        if (!alive_r[lane_idx]) begin
          found   = 1'b1;
          hit_idx = lane_idx;
        end
      end
    end
  end

  always_comb begin
    pos_adv = SW'(pos_r) + SW'(SRCH_LANES);
    if (pos_adv >= SW'(POOL_SIZE)) begin
      pos_adv = pos_adv - SW'(POOL_SIZE);
    end
  end

  assign done      = active_r && (found || (int'(left_r) <= SRCH_LANES));
  assign stat.done = done;
  // nothing free: slot 0 gets overwritten
  assign stat.slot = found ? SLOT_W'(hit_idx) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r  <= '0;
      hint_r   <= '0;
      active_r <= 1'b0;
    end else begin
      if (upd.en) begin
        alive_r[upd.idx[IDX_W-1:0]] <= upd.set;
      end
      if (start) begin
        active_r <= 1'b1;
      end else if (done) begin
        active_r <= 1'b0;
        if (found) begin
          hint_r <= hit_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pos_r  <= hint_r;
      left_r <= CNT_W'(POOL_SIZE);
    end else if (active_r) begin
      pos_r  <= pos_adv[IDX_W-1:0];
      left_r <= left_r - CNT_W'(SRCH_LANES);
    end
  end

endmodule

// ===== rtl/particle_pool_update_unit.sv =====
// particle_pool_update_unit: top level, tick sequencer, particle memory and ageing datapath.
// Depends on ppu_pkg, ppu_ram, ppu_draw, ppu_search.
//
//  port group | dir | contents
//  in_*       | in  | one item per frame tick: tdata[12:0] frame_time
//  out_*      | out | POOL_SIZE items per tick, one per slot, slot 0 first; tlast on the last
//  cfg_*      | in  | register writes: 0 spawn_rate, 1 random_seed
//
// Without respawns a tick passes ACC, CNT and RD, then the ageing sweep: for each memory
// entry, MUL latches it and reads the next one, and WB writes it back on the single port.
// Each respawn adds the free slot search, six random draws and one write.
// Reset: per-entry valid flags make never-written entries read as zero; no clearing pass.
// A stalled output holds the sweep in its write-back cycle; the next tick is taken once the
// sweep is done, while the final item may still wait in the output register.
module particle_pool_update_unit import ppu_pkg::*; #(
  parameter int POOL_SIZE = PPU_POOL_SIZE,
  parameter int FRAC_BITS = PPU_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [12:0] frame_time
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [5:0] slot, [21:6] pos_x, [37:22] pos_y, [53:38] pos_z, [66:54] red,
  // [79:67] green, [92:80] blue, [108:93] alpha, [122:109] remaining_life, [123] alive
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // last
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int COL_W  = FRAC_BITS;
  localparam int LIFE_W = FRAC_BITS + 2;
  localparam int LD_W   = ((LIFE_W > DT_W + 1) ? LIFE_W : DT_W + 1) + 1;
  localparam int PROD_W = 16 + DT_W + 1;

  // memory entry layout, lowest bits first
  localparam int OFF_POS  = 0;
  localparam int OFF_VEL  = 48;
  localparam int OFF_COL  = 96;
  localparam int OFF_ALP  = OFF_COL + 3 * COL_W;
  localparam int OFF_LIFE = OFF_ALP + 16;
  localparam int ENT_W    = OFF_LIFE + LIFE_W;

  ppu_state_t state_r, state_nxt;

  logic [7:0]             spawn_rate_r;
  logic [DT_W-1:0]        dt_r;
  logic [ACC_W-1:0]       acc_r;
  logic [CNT_W-1:0]       n_r;
  slot_t                  slot_r;
  draw_kind_t             draw_sel_r;
  logic [IDX_W-1:0]       age_idx_r;
  logic [POOL_SIZE-1:0]   valid_r;
  logic                   valid_rd_r;

  logic signed [15:0]     vel_new_r [3];
  logic [COL_W-1:0]       col_new_r [3];

  logic signed [15:0]     pos_r [3];
  logic signed [15:0]     vel_r [3];
  logic [COL_W-1:0]       col_r [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [15:0]     alpha_r;
  logic signed [LIFE_W-1:0] life_new_r;
  logic                   alive_new_r;

  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_last_r;

  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_addr;
  logic [ENT_W-1:0]       mem_wdata, mem_rdata, ent;

  logic                   srch_start;
  srch_stat_t             srch_stat;
  alive_upd_t             alive_upd;
  logic                   draw_step;
  logic signed [15:0]     draw_val;
  logic                   seed_load;

  logic [ACC_W:0]         acc_sum;
  logic [ACC_W:0]         n_calc;
  logic                   spawn_go;
  logic                   sweep_end;
  logic                   out_load;

  logic signed [DT_W:0]   dt_s;
  logic signed [LD_W-1:0] life_diff;
  logic signed [LIFE_W-1:0] life_calc;
  logic signed [PROD_W-1:0] prod_calc [3];
  logic signed [15:0]     pos_upd [3];
  logic signed [15:0]     alpha_upd;
  logic signed [31:0]     life_ext;
  logic [31:0]            col_ext [3];

  ppu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ppu_draw #(
    .FRAC_BITS (FRAC_BITS)
  ) u_draw (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_load (seed_load),
    .seed      (cfg_wdata),
    .step      (draw_step),
    .kind      (draw_sel_r),
    .value     (draw_val)
  );

  ppu_search #(
    .POOL_SIZE (POOL_SIZE)
  ) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .upd   (alive_upd),
    .stat  (srch_stat)
  );

  assign seed_load = cfg_we && (cfg_addr == CFG_RANDOM_SEED);

  // ---- spawn accumulator ----
  always_comb begin
    acc_sum = {1'b0, acc_r} + (ACC_W + 1)'(spawn_rate_r) * (ACC_W + 1)'(dt_r);
    n_calc  = {1'b0, acc_r} + (ACC_W + 1)'(ONE - 1);
    n_calc  = n_calc >> FRAC_BITS;
  end

  assign spawn_go  = acc_r > ACC_W'(ONE);
  assign sweep_end = age_idx_r == IDX_W'(POOL_SIZE - 1);
  assign out_load  = (state_r == ST_WB) && (!out_valid_r || out_tready);

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_CNT;
      ST_CNT:    state_nxt = spawn_go ? ST_SEARCH : ST_RD;
      ST_SEARCH: if (srch_stat.done) state_nxt = ST_DRAW;
      ST_DRAW:   if (draw_sel_r == DRAW_BLUE) state_nxt = ST_SPAWN;
      ST_SPAWN:  state_nxt = (n_r == CNT_W'(1)) ? ST_RD : ST_SEARCH;
      ST_RD:     state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_WB;
      ST_WB: begin
        if (out_load) begin
          state_nxt = sweep_end ? ST_IDLE : ST_MUL;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = age_idx_r;
    srch_start    = 1'b0;
    draw_step     = 1'b0;
    alive_upd.en  = 1'b0;
    alive_upd.set = 1'b0;
    alive_upd.idx = SLOT_W'(age_idx_r);
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CNT:  srch_start = spawn_go;
      ST_DRAW: draw_step = 1'b1;
      ST_SPAWN: begin
        mem_we        = 1'b1;
        mem_addr      = slot_r[IDX_W-1:0];
        alive_upd.en  = 1'b1;
        alive_upd.set = 1'b1;
        alive_upd.idx = slot_r;
        srch_start    = n_r != CNT_W'(1);
      end
      ST_RD: begin
        mem_re   = 1'b1;
        mem_addr = '0;
      end
      ST_MUL: begin
        // fetch the next entry while this one is worked on
        mem_re   = !sweep_end;
        mem_addr = age_idx_r + IDX_W'(1);
      end
      ST_WB: begin
        mem_we        = out_load;
        alive_upd.en  = out_load;
        alive_upd.set = alive_new_r;
      end
      default: ;
    endcase
  end

  // ---- ageing datapath ----
  assign ent  = valid_rd_r ? mem_rdata : '0;
  assign dt_s = $signed({1'b0, dt_r});

  always_comb begin
    life_diff = LD_W'($signed(ent[OFF_LIFE +: LIFE_W])) - LD_W'(dt_s);
    if (life_diff < -ONE) begin
      life_calc = LIFE_W'(-ONE);
    end else begin
      life_calc = life_diff[LIFE_W-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      prod_calc[k] = $signed(ent[OFF_VEL + 16 * k +: 16]) * dt_s;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_upd[k] = alive_new_r
                 ? sat16(32'(pos_r[k]) + 32'(prod_r[k] >>> FRAC_BITS))
                 : pos_r[k];
      col_ext[k] = 32'(col_r[k]);
    end
    alpha_upd = alive_new_r ? sat16(32'(alpha_r) - 32'(dt_s)) : alpha_r;
    life_ext  = 32'(life_new_r);
  end

  always_comb begin
    if (state_r == ST_SPAWN) begin
      mem_wdata = {LIFE_W'(ONE), 16'(ONE),
                   col_new_r[2], col_new_r[1], col_new_r[0],
                   vel_new_r[2], vel_new_r[1], vel_new_r[0], 48'd0};
    end else begin
      mem_wdata = {life_new_r, alpha_upd, col_r[2], col_r[1], col_r[0],
                   vel_r[2], vel_r[1], vel_r[0], pos_upd[2], pos_upd[1], pos_upd[0]};
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      spawn_rate_r <= 8'd5;
      acc_r        <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_addr == CFG_SPAWN_RATE)) begin
        spawn_rate_r <= cfg_wdata[7:0];
      end
      if (state_r == ST_ACC) begin
        acc_r <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end else if ((state_r == ST_CNT) && spawn_go) begin
        acc_r <= '0;
      end
      if (mem_we) begin
        valid_r[mem_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      dt_r <= in_tdata[DT_W-1:0];
    end
    if ((state_r == ST_CNT) && spawn_go) begin
      n_r <= (n_calc > (ACC_W + 1)'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : n_calc[CNT_W-1:0];
    end else if (state_r == ST_SPAWN) begin
      n_r <= n_r - CNT_W'(1);
    end
    if (state_r == ST_SEARCH) begin
      slot_r     <= srch_stat.slot;
      draw_sel_r <= DRAW_VEL_X;
    end else if (state_r == ST_DRAW) begin
      draw_sel_r <= draw_kind_t'(draw_sel_r + 3'd1);
      case (draw_sel_r)
        DRAW_VEL_X: vel_new_r[0] <= draw_val;
        DRAW_VEL_Y: vel_new_r[1] <= draw_val;
        DRAW_VEL_Z: vel_new_r[2] <= draw_val;
        DRAW_RED:   col_new_r[0] <= draw_val[COL_W-1:0];
        DRAW_GREEN: col_new_r[1] <= draw_val[COL_W-1:0];
        DRAW_BLUE:  col_new_r[2] <= draw_val[COL_W-1:0];
        default: ;
      endcase
    end
    if (mem_re) begin
      valid_rd_r <= valid_r[mem_addr];
    end
    if (state_r == ST_RD) begin
      age_idx_r <= '0;
    end else if (out_load) begin
      age_idx_r <= age_idx_r + IDX_W'(1);
    end
    if (state_r == ST_MUL) begin
      for (int k = 0; k < 3; k++) begin
        pos_r[k]  <= $signed(ent[OFF_POS + 16 * k +: 16]);
        vel_r[k]  <= $signed(ent[OFF_VEL + 16 * k +: 16]);
        col_r[k]  <= ent[OFF_COL + COL_W * k +: COL_W];
        prod_r[k] <= prod_calc[k];
      end
      alpha_r     <= $signed(ent[OFF_ALP +: 16]);
      life_new_r  <= life_calc;
      alive_new_r <= life_calc > 0;
    end
    if (out_load) begin
      out_data_r <= {4'd0, alive_new_r, life_ext[13:0], alpha_upd,
                     col_ext[2][12:0], col_ext[1][12:0], col_ext[0][12:0],
                     pos_upd[2], pos_upd[1], pos_upd[0], SLOT_W'(age_idx_r)};
      out_last_r <= sweep_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_tick_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("tick taken while the previous one is still in work");

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("particle memory read and written in one cycle");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[SLOT_W-1:0] == SLOT_W'(POOL_SIZE - 1))
    else $error("tlast on a slot other than the last one");

  a_search_state: assert property (@(posedge clk) disable iff (!rst_n)
    srch_stat.done |-> state_r == ST_SEARCH)
    else $error("free slot search finished outside a respawn");
`endif

endmodule
